// ===== rtl/gzhp_pkg.sv =====
// ============================================================================
// gzhp_pkg
// Shared types and constants for the gzip member header parser.
// ============================================================================
package gzhp_pkg;

   // Header walk phases, one-hot encoded.
   typedef enum logic [11:0] {
      PH_MAGIC1  = 12'b0000_0000_0001,
      PH_MAGIC2  = 12'b0000_0000_0010,
      PH_METHOD  = 12'b0000_0000_0100,
      PH_FLAGS   = 12'b0000_0000_1000,
      PH_FIXED   = 12'b0000_0001_0000,
      PH_XLEN_LO = 12'b0000_0010_0000,
      PH_XLEN_HI = 12'b0000_0100_0000,
      PH_XSKIP   = 12'b0000_1000_0000,
      PH_NAME    = 12'b0001_0000_0000,
      PH_COMMENT = 12'b0010_0000_0000,
      PH_HCRC    = 12'b0100_0000_0000,
      PH_PAYLOAD = 12'b1000_0000_0000
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_INVALID     = 2'd1,
      STATUS_UNSUPPORTED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CLASS_HEADER  = 2'd0,
      CLASS_PAYLOAD = 2'd1,
      CLASS_TRAILER = 2'd2,
      CLASS_DISCARD = 2'd3
   } class_type;

   // Where the search for the next optional field starts.
   typedef enum logic [1:0] {
      FROM_XLEN    = 2'd0,
      FROM_NAME    = 2'd1,
      FROM_COMMENT = 2'd2,
      FROM_HCRC    = 2'd3
   } from_type;

   typedef struct packed {
      phase_type  parse_phase;
      logic [31:0] byte_position;
      logic [4:0]  header_flags;
      logic [15:0] skip_left;
      logic [7:0]  length_low_byte;
      status_type  error_status;
   } state_type;

   typedef struct packed {
      class_type  byte_class;
      status_type status;
      logic       message_done;
   } result_type;

   localparam logic [7:0]  MAGIC_FIRST   = 8'h1f;
   localparam logic [7:0]  MAGIC_SECOND  = 8'h8b;
   localparam logic [7:0]  METHOD_DEFLATE = 8'h08;
   localparam logic [7:0]  FLAG_RESERVED = 8'he0;
   localparam int unsigned FLAG_FHCRC    = 1;
   localparam int unsigned FLAG_FEXTRA   = 2;
   localparam int unsigned FLAG_FNAME    = 3;
   localparam int unsigned FLAG_FCOMMENT = 4;
   localparam logic [31:0] MIN_LENGTH    = 32'd18;
   localparam logic [31:0] TRAILER_BYTES = 32'd8;
   localparam logic [15:0] FIXED_BYTES   = 16'd6;
   localparam logic [15:0] HCRC_BYTES    = 16'd2;

   localparam state_type RESET_STATE = '{
      parse_phase:     PH_MAGIC1,
      byte_position:   32'd0,
      header_flags:    5'd0,
      skip_left:       16'd0,
      length_low_byte: 8'd0,
      error_status:    STATUS_OK
   };

endpackage

// ===== rtl/gzhp_step.sv =====
// ============================================================================
// gzhp_step
// Next-state and result logic for one byte of the header walk.
// ============================================================================
module gzhp_step (
   input  gzhp_pkg::state_type  cur_state,
   input  logic [7:0]           data_byte,
   input  logic [31:0]          message_length,
   output gzhp_pkg::state_type  next_state,
   output gzhp_pkg::result_type result
);

   // First optional field at or after the given point that the flags ask for.
   function automatic gzhp_pkg::phase_type enter_field(
      input gzhp_pkg::from_type from,
      input logic [4:0]         flags
   );
      gzhp_pkg::phase_type ph;
      ph = gzhp_pkg::PH_PAYLOAD;
      if (from == gzhp_pkg::FROM_XLEN && flags[gzhp_pkg::FLAG_FEXTRA]) begin
         ph = gzhp_pkg::PH_XLEN_LO;
      end else if ((from == gzhp_pkg::FROM_XLEN || from == gzhp_pkg::FROM_NAME)
                   && flags[gzhp_pkg::FLAG_FNAME]) begin
         ph = gzhp_pkg::PH_NAME;
      end else if (from != gzhp_pkg::FROM_HCRC && flags[gzhp_pkg::FLAG_FCOMMENT]) begin
         ph = gzhp_pkg::PH_COMMENT;
      end else if (flags[gzhp_pkg::FLAG_FHCRC]) begin
         ph = gzhp_pkg::PH_HCRC;
      end
      return ph;
   endfunction

   gzhp_pkg::state_type st;
   logic [31:0] footer;
   logic        at_footer;
   logic [15:0] skip_dec;
   logic [15:0] extra_len;
   logic [32:0] extra_end;
   logic        done;
   logic [32:0] pos_plus_one;

   assign footer       = message_length - gzhp_pkg::TRAILER_BYTES;
   assign at_footer    = cur_state.byte_position >= footer;
   assign skip_dec     = cur_state.skip_left - 16'd1;
   assign extra_len    = {data_byte, cur_state.length_low_byte};
   assign pos_plus_one = {1'b0, cur_state.byte_position} + 33'd1;
   // The extra field overruns the header room when pos + 1 + xlen > footer.
   assign extra_end    = pos_plus_one + {17'd0, extra_len};
   assign done         = pos_plus_one >= {1'b0, message_length};

   always_comb begin
      st = cur_state;
      result.byte_class = gzhp_pkg::CLASS_HEADER;

      if (st.error_status == gzhp_pkg::STATUS_OK && message_length < gzhp_pkg::MIN_LENGTH) begin
         st.error_status = gzhp_pkg::STATUS_INVALID;
      end

      if (st.error_status == gzhp_pkg::STATUS_OK) begin
         if (cur_state.parse_phase == gzhp_pkg::PH_PAYLOAD) begin
            result.byte_class = at_footer ? gzhp_pkg::CLASS_TRAILER : gzhp_pkg::CLASS_PAYLOAD;
         end else if (at_footer) begin
            st.error_status = gzhp_pkg::STATUS_INVALID;
         end else begin
            unique case (cur_state.parse_phase)
               gzhp_pkg::PH_MAGIC1: begin
                  if (data_byte != gzhp_pkg::MAGIC_FIRST) st.error_status = gzhp_pkg::STATUS_INVALID;
                  else st.parse_phase = gzhp_pkg::PH_MAGIC2;
               end
               gzhp_pkg::PH_MAGIC2: begin
                  if (data_byte != gzhp_pkg::MAGIC_SECOND) st.error_status = gzhp_pkg::STATUS_INVALID;
                  else st.parse_phase = gzhp_pkg::PH_METHOD;
               end
               gzhp_pkg::PH_METHOD: begin
                  if (data_byte != gzhp_pkg::METHOD_DEFLATE) begin
                     st.error_status = gzhp_pkg::STATUS_INVALID;
                  end else begin
                     st.parse_phase = gzhp_pkg::PH_FLAGS;
                  end
               end
               gzhp_pkg::PH_FLAGS: begin
                  if ((data_byte & gzhp_pkg::FLAG_RESERVED) != 8'd0) begin
                     st.error_status = gzhp_pkg::STATUS_UNSUPPORTED;
                  end else begin
                     st.header_flags = data_byte[4:0];
                     st.skip_left    = gzhp_pkg::FIXED_BYTES;
                     st.parse_phase  = gzhp_pkg::PH_FIXED;
                  end
               end
               gzhp_pkg::PH_FIXED: begin
                  st.skip_left = skip_dec;
                  if (skip_dec == 16'd0) begin
                     st.parse_phase = enter_field(gzhp_pkg::FROM_XLEN, cur_state.header_flags);
                  end
               end
               gzhp_pkg::PH_XLEN_LO: begin
                  st.length_low_byte = data_byte;
                  st.parse_phase     = gzhp_pkg::PH_XLEN_HI;
               end
               gzhp_pkg::PH_XLEN_HI: begin
                  if (extra_end > {1'b0, footer}) begin
                     st.error_status = gzhp_pkg::STATUS_INVALID;
                  end else if (extra_len == 16'd0) begin
                     st.parse_phase = enter_field(gzhp_pkg::FROM_NAME, cur_state.header_flags);
                  end else begin
                     st.skip_left   = extra_len;
                     st.parse_phase = gzhp_pkg::PH_XSKIP;
                  end
               end
               gzhp_pkg::PH_XSKIP: begin
                  st.skip_left = skip_dec;
                  if (skip_dec == 16'd0) begin
                     st.parse_phase = enter_field(gzhp_pkg::FROM_NAME, cur_state.header_flags);
                  end
               end
               gzhp_pkg::PH_NAME: begin
                  if (data_byte == 8'd0) begin
                     st.parse_phase = enter_field(gzhp_pkg::FROM_COMMENT,
                                                  cur_state.header_flags);
                  end
               end
               gzhp_pkg::PH_COMMENT: begin
                  if (data_byte == 8'd0) begin
                     st.parse_phase = enter_field(gzhp_pkg::FROM_HCRC, cur_state.header_flags);
                  end
               end
               gzhp_pkg::PH_HCRC: begin
                  st.skip_left = skip_dec;
                  if (skip_dec == 16'd0) st.parse_phase = gzhp_pkg::PH_PAYLOAD;
               end
               default: begin
                  st.error_status = gzhp_pkg::STATUS_INVALID;
               end
            endcase

            // Entering the header CRC always loads its two-byte count.
            if (st.error_status == gzhp_pkg::STATUS_OK &&
                cur_state.parse_phase != gzhp_pkg::PH_HCRC &&
                st.parse_phase == gzhp_pkg::PH_HCRC) begin
               st.skip_left = gzhp_pkg::HCRC_BYTES;
            end
         end
      end

      if (st.error_status != gzhp_pkg::STATUS_OK) begin
         result.byte_class = gzhp_pkg::CLASS_DISCARD;
      end
      result.status       = st.error_status;
      result.message_done = done;

      if (done) begin
         next_state = gzhp_pkg::RESET_STATE;
      end else begin
         next_state               = st;
         next_state.byte_position = pos_plus_one[31:0];
      end
   end

endmodule

// ===== rtl/gzip_header_parser_unit.sv =====
// ============================================================================
// gzip_header_parser_unit
// Byte-serial gzip member header parser with registered request and result.
// ============================================================================
//
// Usage: one byte of a gzip message enters per request on req_data_byte,
// with the total message length repeated on req_message_length for every
// byte. Each request yields exactly one response: rsp_byte_class tells
// whether the byte is header, deflate payload, trailer or discarded after an
// error, rsp_status carries the sticky error code, and rsp_message_done marks
// the last byte of a message, after which the parser starts over.
//
// A request is taken at a clock edge where req_valid is high and req_stall
// is low. It waits in the request register, is parsed, and its response is
// loaded into the response register at the edge where it advances, after
// which rsp_valid is high. One request is accepted and one response
// delivered per cycle while rsp_stall stays low; the parse step between the
// two registers is the only state update.
//
// When the receiver raises rsp_stall, the held response stays stable and
// the byte in the request register waits; req_stall rises only once the
// request register is full and cannot move on. Synchronous reset empties
// both registers and returns the parser to the first magic byte phase.
//
module gzip_header_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_message_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_byte_class,
   output logic [1:0]  rsp_status,
   output logic        rsp_message_done
);

   // Request register.
   logic        req_vld_ff, req_vld_in;
   logic [7:0]  byte_ff;
   logic [31:0] length_ff;

   // Parser state.
   gzhp_pkg::state_type state_ff, state_in, step_state;

   // Response register.
   logic                 rsp_vld_ff, rsp_vld_in;
   gzhp_pkg::result_type result_ff, step_result;

   logic accept;
   logic advance;

   // The held byte moves into the response register whenever that register
   // is empty or is being drained in this same cycle.
   assign advance   = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = req_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   gzhp_step u_step (
      .cur_state      (state_ff),
      .data_byte      (byte_ff),
      .message_length (length_ff),
      .next_state     (step_state),
      .result         (step_result)
   );

   always_comb begin
      if (accept) req_vld_in = 1'b1;
      else if (advance) req_vld_in = 1'b0;
      else req_vld_in = req_vld_ff;

      state_in = advance ? step_state : state_ff;

      if (advance) rsp_vld_in = 1'b1;
      else if (rsp_vld_ff && !rsp_stall) rsp_vld_in = 1'b0;
      else rsp_vld_in = rsp_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= gzhp_pkg::RESET_STATE;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         state_ff   <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff   <= req_data_byte;
         length_ff <= req_message_length;
      end
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_byte_class   = result_ff.byte_class;
   assign rsp_status       = result_ff.status;
   assign rsp_message_done = result_ff.message_done;

endmodule
